// ----- rtl/core/assert_macros.svh -----
// Assertion helpers used by the checker.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked on every rising clock edge, off while reset is high.
`define ASSERT_IMP(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Implication whose consequent is checked in the next cycle, also during reset.
`define ASSERT_NEXT(label, clk, ante, cons, msg) \
  label: assert property (@(posedge clk) (ante) |=> (cons)) else $error(msg);

`endif

// ----- rtl/core/udpdmx_pkg.sv -----
package udpdmx_pkg;

  localparam int PORT_SLOTS_DEF    = 8;
  localparam int MAILBOX_BYTES_DEF = 1024;

  typedef enum logic [2:0] {
    CMD_BIND    = 3'd0,
    CMD_UNBIND  = 3'd1,
    CMD_HEADER  = 3'd2,
    CMD_PAYLOAD = 3'd3,
    CMD_POLL    = 3'd4,
    CMD_READ    = 3'd5,
    CMD_NONE    = 3'd6
  } cmd_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_MISS  = 2'd1,
    ST_EMPTY = 2'd2
  } status_t;

  typedef struct packed {
    cmd_t        cmd;
    logic [15:0] port;
    logic        has_callback;
    logic [31:0] source_ip;
    logic [15:0] sender_port;
    logic [15:0] udp_length;
    logic [7:0]  payload_byte;
    logic [2:0]  slot;
    logic [9:0]  offset;
    logic [10:0] limit;
    logic        zero_copy;
  } req_t;

  // queue head seen by the back end
  typedef struct packed {
    logic valid;
    req_t req;
  } queue_head_t;

endpackage

// ----- rtl/core/udpdmx_req_if.sv -----
interface udpdmx_req_if;
  logic        valid;
  logic        ready;
  logic [2:0]  command;
  logic [15:0] port;
  logic        has_callback;
  logic [31:0] source_ip;
  logic [15:0] sender_port;
  logic [15:0] udp_length;
  logic [7:0]  payload_byte;
  logic [2:0]  slot;
  logic [9:0]  offset;
  logic [10:0] limit;
  logic        zero_copy;

  modport source (
    output valid, command, port, has_callback, source_ip, sender_port, udp_length,
           payload_byte, slot, offset, limit, zero_copy,
    input  ready
  );
  modport sink (
    input  valid, command, port, has_callback, source_ip, sender_port, udp_length,
           payload_byte, slot, offset, limit, zero_copy,
    output ready
  );
endinterface

// ----- rtl/core/udpdmx_rsp_if.sv -----
interface udpdmx_rsp_if;
  logic        valid;
  logic        ready;
  logic [1:0]  status;
  logic [2:0]  slot_index;
  logic [10:0] size;
  logic [15:0] full_length;
  logic        notify;
  logic [31:0] from_ip;
  logic [15:0] from_port;
  logic [7:0]  data_out;

  modport source (
    output valid, status, slot_index, size, full_length, notify, from_ip, from_port,
           data_out,
    input  ready
  );
  modport sink (
    input  valid, status, slot_index, size, full_length, notify, from_ip, from_port,
           data_out,
    output ready
  );
endinterface

// ----- rtl/core/udpdmx_front.sv -----
module udpdmx_front (
  input  logic                    clk,
  input  logic                    rst,
  udpdmx_req_if.sink              req,
  output udpdmx_pkg::queue_head_t head,
  input  logic                    pop
);

  udpdmx_pkg::req_t entry [2];
  udpdmx_pkg::req_t incoming;
  logic             wr_ptr;
  logic             rd_ptr;
  logic [1:0]       count;
  logic             push;

  assign req.ready = (count != 2'd2);
  assign push      = req.valid && req.ready;

  // classify: unknown command codes fold into one kind
  always_comb begin
    incoming.cmd = (req.command > 3'(udpdmx_pkg::CMD_READ)) ?
                   udpdmx_pkg::CMD_NONE : udpdmx_pkg::cmd_t'(req.command);
    incoming.port         = req.port;
    incoming.has_callback = req.has_callback;
    incoming.source_ip    = req.source_ip;
    incoming.sender_port  = req.sender_port;
    incoming.udp_length   = req.udp_length;
    incoming.payload_byte = req.payload_byte;
    incoming.slot         = req.slot;
    incoming.offset       = req.offset;
    incoming.limit        = req.limit;
    incoming.zero_copy    = req.zero_copy;
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entry[wr_ptr] <= incoming;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (pop)  rd_ptr <= ~rd_ptr;
      count <= count + 2'(push) - 2'(pop);
    end
  end

  assign head.valid = (count != 2'd0);
  assign head.req   = entry[rd_ptr];

endmodule

// ----- rtl/core/udpdmx_back.sv -----
module udpdmx_back #(
  parameter int PORT_SLOTS    = udpdmx_pkg::PORT_SLOTS_DEF,
  parameter int MAILBOX_BYTES = udpdmx_pkg::MAILBOX_BYTES_DEF
) (
  input  logic                    clk,
  input  logic                    rst,
  input  udpdmx_pkg::queue_head_t head,
  output logic                    pop,
  udpdmx_rsp_if.source            rsp
);

  localparam int SW = (PORT_SLOTS > 1) ? $clog2(PORT_SLOTS) : 1;
  localparam int OW = $clog2(MAILBOX_BYTES + 1);
  localparam int AW = $clog2(PORT_SLOTS * MAILBOX_BYTES);

  logic [15:0]   bound_port     [PORT_SLOTS];
  logic          callback_bound [PORT_SLOTS];
  logic [OW-1:0] stored_size    [PORT_SLOTS];
  logic [31:0]   stored_ip      [PORT_SLOTS];
  logic [15:0]   stored_port    [PORT_SLOTS];
  logic [7:0]    payload_mem    [PORT_SLOTS * MAILBOX_BYTES];

  logic [SW-1:0] fill_slot;
  logic [OW-1:0] fill_offset;
  logic          fill_active;

  udpdmx_pkg::req_t r;
  logic          go;
  logic          hit, bind_found;
  logic [SW-1:0] hit_idx, bind_idx, sel_idx;
  logic          slot_ok, read_ok, pay_ok, poll_ok;
  logic [15:0]   len;
  logic [OW-1:0] keep;
  logic [11:0]   poll_size;
  logic [AW-1:0] wr_addr, rd_addr;

  udpdmx_pkg::status_t status_next;
  logic [SW-1:0] sidx_next;
  logic [10:0]   size_next;
  logic [15:0]   full_next;
  logic          notify_next;
  logic [31:0]   ip_next;
  logic [15:0]   port_next;

  logic          out_valid;
  logic [1:0]    out_status;
  logic [2:0]    out_slot;
  logic [10:0]   out_size;
  logic [15:0]   out_full;
  logic          out_notify;
  logic [31:0]   out_ip;
  logic [15:0]   out_port;
  logic          out_is_read;
  logic [7:0]    rd_data;

  assign r   = head.req;
  assign go  = head.valid && (!out_valid || rsp.ready);
  assign pop = go;

  // first slot matching the port, and first slot matching or free for bind
  always_comb begin
    hit        = 1'b0;
    hit_idx    = '0;
    bind_found = 1'b0;
    bind_idx   = '0;
    for (int i = PORT_SLOTS - 1; i >= 0; i--) begin
      if (r.port != 16'd0 && bound_port[i] == r.port) begin
        hit     = 1'b1;
        hit_idx = SW'(i);
      end
      if (r.port != 16'd0 && (bound_port[i] == r.port || bound_port[i] == 16'd0)) begin
        bind_found = 1'b1;
        bind_idx   = SW'(i);
      end
    end
  end

  always_comb begin
    sel_idx = SW'(r.slot);
    slot_ok = (32'(r.slot) < PORT_SLOTS);
    read_ok = slot_ok && (32'(r.offset) < MAILBOX_BYTES);
    len     = (r.udp_length < 16'd8) ? 16'd0 : r.udp_length - 16'd8;
    keep    = (32'(len) < MAILBOX_BYTES) ? OW'(len) : OW'(MAILBOX_BYTES);
    pay_ok  = fill_active && (fill_offset < stored_size[fill_slot]);
    poll_ok = slot_ok && !(r.zero_copy && callback_bound[sel_idx])
              && (stored_size[sel_idx] != '0);
    poll_size = 12'(stored_size[sel_idx]);
    if (!r.zero_copy && 12'(r.limit) < poll_size) poll_size = 12'(r.limit);
    wr_addr = AW'(fill_slot) * AW'(MAILBOX_BYTES) + AW'(fill_offset);
    rd_addr = AW'(sel_idx) * AW'(MAILBOX_BYTES) + AW'(r.offset);
  end

  always_comb begin
    status_next = udpdmx_pkg::ST_MISS;
    sidx_next   = '0;
    size_next   = '0;
    full_next   = '0;
    notify_next = 1'b0;
    ip_next     = '0;
    port_next   = '0;
    unique case (r.cmd)
      udpdmx_pkg::CMD_BIND: begin
        if (bind_found) begin
          status_next = udpdmx_pkg::ST_OK;
          sidx_next   = bind_idx;
        end
      end
      udpdmx_pkg::CMD_UNBIND: begin
        if (hit) begin
          status_next = udpdmx_pkg::ST_OK;
          sidx_next   = hit_idx;
        end
      end
      udpdmx_pkg::CMD_HEADER: begin
        if (hit) begin
          status_next = udpdmx_pkg::ST_OK;
          sidx_next   = hit_idx;
          size_next   = 11'(keep);
          full_next   = len;
          notify_next = callback_bound[hit_idx];
        end
      end
      udpdmx_pkg::CMD_PAYLOAD: begin
        sidx_next = fill_slot;
        if (pay_ok) begin
          status_next = udpdmx_pkg::ST_OK;
          size_next   = 11'(fill_offset + OW'(1));
        end else begin
          size_next   = 11'(fill_offset);
        end
      end
      udpdmx_pkg::CMD_POLL: begin
        if (slot_ok) begin
          sidx_next = sel_idx;
          if (poll_ok) begin
            status_next = udpdmx_pkg::ST_OK;
            size_next   = 11'(poll_size);
            ip_next     = stored_ip[sel_idx];
            port_next   = stored_port[sel_idx];
          end else begin
            status_next = udpdmx_pkg::ST_EMPTY;
          end
        end
      end
      udpdmx_pkg::CMD_READ: begin
        if (read_ok) begin
          status_next = udpdmx_pkg::ST_OK;
          sidx_next   = sel_idx;
        end
      end
      default: ;
    endcase
  end

  // table and fill state
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < PORT_SLOTS; i++) begin
        bound_port[i]     <= '0;
        callback_bound[i] <= 1'b0;
        stored_size[i]    <= '0;
      end
      fill_slot   <= '0;
      fill_offset <= '0;
      fill_active <= 1'b0;
    end else if (go) begin
      case (r.cmd)
        udpdmx_pkg::CMD_BIND: begin
          if (bind_found && bound_port[bind_idx] == 16'd0) begin
            bound_port[bind_idx]     <= r.port;
            callback_bound[bind_idx] <= r.has_callback;
          end
        end
        udpdmx_pkg::CMD_UNBIND: begin
          if (hit) begin
            bound_port[hit_idx]     <= '0;
            callback_bound[hit_idx] <= 1'b0;
            stored_size[hit_idx]    <= '0;
            if (fill_slot == hit_idx) fill_active <= 1'b0;
          end
        end
        udpdmx_pkg::CMD_HEADER: begin
          fill_active <= 1'b0;
          if (hit) begin
            stored_size[hit_idx] <= keep;
            fill_slot            <= hit_idx;
            fill_offset          <= '0;
            fill_active          <= (keep != '0);
          end
        end
        udpdmx_pkg::CMD_PAYLOAD: begin
          if (pay_ok) begin
            fill_offset <= fill_offset + OW'(1);
            if (fill_offset + OW'(1) >= stored_size[fill_slot]) fill_active <= 1'b0;
          end else begin
            fill_active <= 1'b0;
          end
        end
        udpdmx_pkg::CMD_POLL: begin
          if (poll_ok) begin
            stored_size[sel_idx] <= '0;
            if (fill_slot == sel_idx) fill_active <= 1'b0;
          end
        end
        default: ;
      endcase
    end
  end

  // sender fields, written by a matched header
  always_ff @(posedge clk) begin
    if (go && r.cmd == udpdmx_pkg::CMD_HEADER && hit) begin
      stored_ip[hit_idx]   <= r.source_ip;
      stored_port[hit_idx] <= r.sender_port;
    end
  end

  always_ff @(posedge clk) begin
    if (go && r.cmd == udpdmx_pkg::CMD_PAYLOAD && pay_ok) begin
      payload_mem[wr_addr] <= r.payload_byte;
    end
    if (go && r.cmd == udpdmx_pkg::CMD_READ && read_ok) begin
      rd_data <= payload_mem[rd_addr];
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (go) begin
      out_valid <= 1'b1;
    end else if (rsp.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (go) begin
      out_status  <= status_next;
      out_slot    <= 3'(sidx_next);
      out_size    <= size_next;
      out_full    <= full_next;
      out_notify  <= notify_next;
      out_ip      <= ip_next;
      out_port    <= port_next;
      out_is_read <= (r.cmd == udpdmx_pkg::CMD_READ) && read_ok;
    end
  end

  assign rsp.valid       = out_valid;
  assign rsp.status      = out_status;
  assign rsp.slot_index  = out_slot;
  assign rsp.size        = out_size;
  assign rsp.full_length = out_full;
  assign rsp.notify      = out_notify;
  assign rsp.from_ip     = out_ip;
  assign rsp.from_port   = out_port;
  assign rsp.data_out    = out_is_read ? rd_data : 8'd0;

endmodule

// ----- rtl/core/udp_port_demux_mailbox_core.sv -----
// UDP port demultiplexer with one-datagram mailboxes per bound port. Every
// request (bind, unbind, datagram header, payload byte, poll, read byte)
// returns exactly one response, in order. A two-entry request queue decouples
// the intake from the executing back end; the back end retires one request per
// cycle while the response register is free or being drained, so the sustained
// rate is one request per cycle, and each request passes from acceptance to
// response through the queue and then the response register. Port lookup is
// a parallel compare over all slots; payload sits in a single-port-write,
// registered-read byte memory of PORT_SLOTS * MAILBOX_BYTES entries, which
// needs no clearing after reset.
module udp_port_demux_mailbox_core #(
  parameter int PORT_SLOTS    = udpdmx_pkg::PORT_SLOTS_DEF,
  parameter int MAILBOX_BYTES = udpdmx_pkg::MAILBOX_BYTES_DEF
) (
  input  logic         clk,
  input  logic         rst,
  udpdmx_req_if.sink   req,
  udpdmx_rsp_if.source rsp
);

  udpdmx_pkg::queue_head_t head;
  logic                    pop;

  udpdmx_front u_front (
    .clk  (clk),
    .rst  (rst),
    .req  (req),
    .head (head),
    .pop  (pop)
  );

  udpdmx_back #(
    .PORT_SLOTS    (PORT_SLOTS),
    .MAILBOX_BYTES (MAILBOX_BYTES)
  ) u_back (
    .clk  (clk),
    .rst  (rst),
    .head (head),
    .pop  (pop),
    .rsp  (rsp)
  );

endmodule

// ----- rtl/core/udpdmx_checker.sv -----
`include "assert_macros.svh"

module udpdmx_checker (
  input logic        clk,
  input logic        rst,
  input logic        rsp_valid,
  input logic        rsp_ready,
  input logic [1:0]  status,
  input logic [10:0] size,
  input logic        notify,
  input logic [31:0] from_ip,
  input logic [15:0] full_length
);

  `ASSERT_IMP(a_rsp_hold, clk, rst, rsp_valid && !rsp_ready, ##1 (rsp_valid && $stable(status)), "response dropped while stalled")
  `ASSERT_NEXT(a_rst_idle, clk, rst, !rsp_valid, "response valid after reset")
  `ASSERT_IMP(a_status_code, clk, rst, rsp_valid, status != 2'd3, "undefined status code")
  `ASSERT_IMP(a_empty_clean, clk, rst, rsp_valid && status == 2'd2, size == 11'd0 && from_ip == 32'd0 && !notify, "empty mailbox response carries data")
  `ASSERT_IMP(a_miss_clean, clk, rst, rsp_valid && status == 2'd1, !notify && full_length == 16'd0, "miss response carries header data")

endmodule

bind udp_port_demux_mailbox_core udpdmx_checker u_checker (
  .clk         (clk),
  .rst         (rst),
  .rsp_valid   (rsp.valid),
  .rsp_ready   (rsp.ready),
  .status      (rsp.status),
  .size        (rsp.size),
  .notify      (rsp.notify),
  .from_ip     (rsp.from_ip),
  .full_length (rsp.full_length)
);

// ----- verif/udpdmx_tb_pkg.sv -----
package udpdmx_tb_pkg;
  import udpdmx_pkg::*;

  typedef struct packed {
    logic [1:0]  status;
    logic [2:0]  slot_index;
    logic [10:0] size;
    logic [15:0] full_length;
    logic        notify;
    logic [31:0] from_ip;
    logic [15:0] from_port;
    logic [7:0]  data_out;
  } answer_t;

  localparam int NSLOT = PORT_SLOTS_DEF;
  localparam int MBOX  = MAILBOX_BYTES_DEF;

  class mailbox_scoreboard;
    logic [15:0] port_tab [NSLOT];
    logic        cb_tab [NSLOT];
    int          held [NSLOT];
    logic [31:0] src_ip [NSLOT];
    logic [15:0] src_port [NSLOT];
    logic [7:0]  bytes [NSLOT*MBOX];
    int          fslot, foff;
    bit          fopen;
    answer_t     pending [$];
    int          errors, checked;

    function new();
      for (int i = 0; i < NSLOT; i++) begin
        port_tab[i] = '0; cb_tab[i] = 1'b0; held[i] = 0;
      end
      fslot = 0; foff = 0; fopen = 0; errors = 0; checked = 0;
    endfunction

    function int lookup(logic [15:0] p);
      if (p == 16'd0) return -1;
      for (int i = 0; i < NSLOT; i++) if (port_tab[i] == p) return i;
      return -1;
    endfunction

    function void note_request(req_t r);
      answer_t a;
      int hit, len, keep;
      a = '0;
      a.status = ST_MISS;
      case (r.cmd)
        CMD_BIND: if (r.port != 16'd0) begin
          for (int i = 0; i < NSLOT; i++) begin
            if (port_tab[i] == r.port) begin
              a.status = ST_OK; a.slot_index = 3'(i); break;
            end
            if (port_tab[i] == 16'd0) begin
              port_tab[i] = r.port; cb_tab[i] = r.has_callback;
              a.status = ST_OK; a.slot_index = 3'(i); break;
            end
          end
        end
        CMD_UNBIND: begin
          hit = lookup(r.port);
          if (hit >= 0) begin
            port_tab[hit] = '0; cb_tab[hit] = 1'b0; held[hit] = 0;
            if (fopen && fslot == hit) fopen = 0;
            a.status = ST_OK; a.slot_index = 3'(hit);
          end
        end
        CMD_HEADER: begin
          fopen = 0;
          hit = lookup(r.port);
          if (hit >= 0) begin
            len = (r.udp_length < 16'd8) ? 0 : int'(r.udp_length) - 8;
            keep = (len < MBOX) ? len : MBOX;
            held[hit] = keep; src_ip[hit] = r.source_ip; src_port[hit] = r.sender_port;
            fslot = hit; foff = 0; fopen = (keep != 0);
            a.status = ST_OK; a.slot_index = 3'(hit); a.size = 11'(keep);
            a.full_length = 16'(len); a.notify = cb_tab[hit];
          end
        end
        CMD_PAYLOAD: begin
          a.slot_index = 3'(fslot);
          if (fopen && foff < held[fslot]) begin
            bytes[fslot*MBOX + foff] = r.payload_byte;
            foff++;
            a.status = ST_OK;
            if (foff >= held[fslot]) fopen = 0;
          end else fopen = 0;
          a.size = 11'(foff);
        end
        CMD_POLL: begin
          a.slot_index = r.slot;
          if ((r.zero_copy && cb_tab[r.slot]) || held[r.slot] == 0) a.status = ST_EMPTY;
          else begin
            a.size = 11'(held[r.slot]);
            if (!r.zero_copy && r.limit < held[r.slot]) a.size = r.limit;
            a.from_ip = src_ip[r.slot]; a.from_port = src_port[r.slot];
            held[r.slot] = 0;
            if (fopen && fslot == r.slot) fopen = 0;
            a.status = ST_OK;
          end
        end
        CMD_READ: begin
          a.slot_index = r.slot; a.status = ST_OK;
          a.data_out = bytes[r.slot*MBOX + r.offset];
        end
        default: ;
      endcase
      pending.push_back(a);
    endfunction

    function void check_answer(answer_t got, time t);
      answer_t e;
      if (pending.size() == 0) begin
        $display("%0t: unexpected response %h", t, got);
        errors++;
        return;
      end
      e = pending.pop_front();
      checked++;
      if (got.status !== e.status) report(t, "status", e.status, got.status);
      if (got.slot_index !== e.slot_index) report(t, "slot_index", e.slot_index, got.slot_index);
      if (got.size !== e.size) report(t, "size", e.size, got.size);
      if (got.full_length !== e.full_length)
        report(t, "full_length", e.full_length, got.full_length);
      if (got.notify !== e.notify) report(t, "notify", e.notify, got.notify);
      if (got.from_ip !== e.from_ip) report(t, "from_ip", e.from_ip, got.from_ip);
      if (got.from_port !== e.from_port) report(t, "from_port", e.from_port, got.from_port);
      if (got.data_out !== e.data_out) report(t, "data_out", e.data_out, got.data_out);
    endfunction

    function void report(time t, string f, logic [31:0] e, logic [31:0] g);
      $display("%0t: %s mismatch, expected %h, actual %h", t, f, e, g);
      errors++;
    endfunction
  endclass
endpackage

// ----- verif/testbench.sv -----
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import udpdmx_pkg::*;
  import udpdmx_tb_pkg::*;

  logic clk = 0;
  logic rst = 1;
  udpdmx_req_if req ();
  udpdmx_rsp_if rsp ();

  udp_port_demux_mailbox_core dut (.clk(clk), .rst(rst), .req(req.sink), .rsp(rsp.source));

  mailbox_scoreboard board = new();
  int send_idle = 0, recv_idle = 0;
  int quiet = 0;
  int sent = 0;
  logic [15:0] ports [6] = '{16'd7, 16'd53, 16'd1, 16'd65535, 16'd8080, 16'd123};
  bit written [NSLOT*MBOX];

  initial forever #5 clk = ~clk;

  initial begin
    req.valid = 0; req.command = 0; req.port = 0; req.has_callback = 0;
    req.source_ip = 0; req.sender_port = 0; req.udp_length = 0; req.payload_byte = 0;
    req.slot = 0; req.offset = 0; req.limit = 0; req.zero_copy = 0;
    rsp.ready = 0;
  end

  always @(posedge clk) begin
    rsp.ready <= !rst && ($urandom_range(99) >= recv_idle);
    if (!rst && rsp.valid && rsp.ready)
      board.check_answer({rsp.status, rsp.slot_index, rsp.size, rsp.full_length,
                          rsp.notify, rsp.from_ip, rsp.from_port, rsp.data_out}, $time);
    if ((req.valid && req.ready) || (rsp.valid && rsp.ready)) quiet <= 0;
    else quiet <= quiet + 1;
    if (quiet > 5000) begin
      $display("watchdog expired at %0t", $time);
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // Read of never-written bytes is avoided by redirecting to a poll.
  task automatic send(req_t r);
    if (r.cmd == CMD_READ && !written[r.slot*MBOX + r.offset]) r.cmd = CMD_POLL;
    while ($urandom_range(99) < send_idle) begin
      req.valid <= 1'b0;
      @(posedge clk);
    end
    req.valid <= 1; req.command <= r.cmd; req.port <= r.port;
    req.has_callback <= r.has_callback; req.source_ip <= r.source_ip;
    req.sender_port <= r.sender_port; req.udp_length <= r.udp_length;
    req.payload_byte <= r.payload_byte; req.slot <= r.slot; req.offset <= r.offset;
    req.limit <= r.limit; req.zero_copy <= r.zero_copy;
    @(posedge clk);
    while (!req.ready) @(posedge clk);
    if (r.cmd == CMD_PAYLOAD && board.fopen && board.foff < board.held[board.fslot])
      written[board.fslot*MBOX + board.foff] = 1;
    board.note_request(r);
    sent++;
  endtask

  function automatic req_t noise();
    req_t r;
    r = '0;
    r.cmd = cmd_t'($urandom_range(7));
    r.port = 16'($urandom); r.has_callback = 1'($urandom); r.source_ip = $urandom;
    r.sender_port = 16'($urandom); r.udp_length = 16'($urandom);
    r.payload_byte = 8'($urandom);
    r.slot = 3'($urandom); r.offset = 10'($urandom); r.limit = 11'($urandom_range(1024));
    r.zero_copy = 1'($urandom);
    return r;
  endfunction

  task automatic datagram(logic [15:0] p, int n, bit partial);
    req_t r;
    r = noise();
    r.cmd = CMD_HEADER; r.port = p;
    r.udp_length = ($urandom_range(9) == 0) ? 16'($urandom_range(7)) : 16'(n + 8);
    send(r);
    if (partial) n = $urandom_range(n);
    for (int k = 0; k < n + 1; k++) begin
      r = noise(); r.cmd = CMD_PAYLOAD; send(r);
    end
  endtask

  task automatic basic(cmd_t c, logic [15:0] p, bit cb, logic [2:0] s);
    req_t r;
    r = noise(); r.cmd = c; r.port = p; r.has_callback = cb; r.slot = s;
    send(r);
  endtask

  task automatic random_phase(int count);
    req_t r;
    int start;
    int n;
    start = sent;
    while (sent - start < count) begin
      case ($urandom_range(9))
        0, 1: basic(CMD_BIND, ports[$urandom_range(5)], 1'($urandom), 3'd0);
        2: basic(CMD_UNBIND, ports[$urandom_range(5)], 1'b0, 3'd0);
        3, 4: begin
          n = ($urandom_range(19) == 0) ? $urandom_range(1100) : $urandom_range(12);
          // keep the phase near its request budget
          if (n > count - (sent - start)) n = count - (sent - start);
          datagram(ports[$urandom_range(5)], n, $urandom_range(3) == 0);
        end
        5, 6: begin
          r = noise(); r.cmd = CMD_POLL; r.limit = 11'($urandom_range(12));
          if ($urandom_range(3) == 0) r.limit = 11'($urandom_range(1024));
          send(r);
        end
        7, 8: begin r = noise(); r.cmd = CMD_READ; r.offset = 10'($urandom_range(15));
          send(r); end
        default: begin
          r = noise();
          if (r.cmd == CMD_READ) r.offset = 10'($urandom_range(15));
          send(r);
        end
      endcase
    end
  endtask

  initial begin
    req_t r;
    repeat (3) @(posedge clk);
    rst <= 0;
    @(posedge clk);
    // directed: port zero, binds to fill the table, rebind, overflow, datagrams, polls, read, unbind
    basic(CMD_BIND, 16'd0, 1'b0, 3'd0);
    basic(CMD_UNBIND, 16'd5, 1'b0, 3'd0);
    for (int i = 0; i < NSLOT; i++) basic(CMD_BIND, 16'(100 + i), i[0], 3'd0);
    basic(CMD_BIND, 16'd100, 1'b1, 3'd0);
    basic(CMD_BIND, 16'd65535, 1'b0, 3'd0);
    basic(CMD_HEADER, 16'd0, 1'b0, 3'd0);
    r = noise(); r.cmd = CMD_PAYLOAD; send(r);
    datagram(16'd100, 3, 0);
    datagram(16'd101, 2, 0);
    r = noise(); r.cmd = CMD_HEADER; r.port = 16'd102; r.udp_length = 16'hFFFF; send(r);
    r = noise(); r.cmd = CMD_POLL; r.slot = 3'd1; r.zero_copy = 1'b1; send(r);
    r = noise(); r.cmd = CMD_POLL; r.slot = 3'd0; r.zero_copy = 1'b0; r.limit = 11'd1;
    send(r);
    r = noise(); r.cmd = CMD_POLL; r.slot = 3'd0; send(r);
    r = noise(); r.cmd = CMD_READ; r.slot = 3'd0; r.offset = 10'd2; send(r);
    r = noise(); r.cmd = CMD_NONE; send(r);
    for (int i = 0; i < NSLOT; i++) basic(CMD_UNBIND, 16'(100 + i), 1'b0, 3'd0);

    send_idle = 21; recv_idle = 66; random_phase(530);
    send_idle = 66; recv_idle = 21; random_phase(530);
    send_idle = 0;  recv_idle = 0;  random_phase(540);
    req.valid <= 1'b0;

    while (board.pending.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    $display("Sent %0d requests over binds, datagrams, polls and reads; checked %0d responses.",
             sent, board.checked);
    if (board.errors == 0 && board.pending.size() == 0) $display("RESULT: OK");
    else $display("RESULT: ERROR");
    $finish;
  end
endmodule
